FILE: hw/rtl/lzss_ring_decompressor_assert.svh
// Assertion macros used by the checker file of the decompressor.
`ifndef LZSS_RING_DECOMPRESSOR_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzrd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzrd assertion failed");

`endif

FILE: hw/rtl/lzrd_pkg.sv
// Constants of the LZSS ring decompressor.
package lzrd_pkg;

  localparam int unsigned RING_SIZE = 4096;
  localparam int unsigned LOOKAHEAD = 18;
  localparam int unsigned MIN_MATCH = 2;
  localparam int unsigned BYTE_W    = 8;

  localparam int unsigned PTR_W    = $clog2(RING_SIZE);
  localparam int unsigned FILL_W   = PTR_W + 1;
  localparam int unsigned CNT_W    = $clog2(LOOKAHEAD + 3);
  localparam int unsigned EVER_W   = $clog2(LOOKAHEAD + 1);
  localparam int unsigned SEED_END = RING_SIZE - LOOKAHEAD;

  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [3:0]        FLAGS_PER_GROUP = 4'd8;

endpackage

FILE: hw/rtl/lzrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lzss_ring_decompressor.sv
// Flag bytes and match low bytes are taken while idle and give no output. A literal goes
// from the put state into the output register; each byte of a match goes from the read state
// (ring read) to the put state (ring write and output), which waits while the output is stalled.
// A match copies 3 to 18 bytes; input is stalled until the last byte of a literal or match is put.
// Reset: control state clears at once; the ring needs no clearing pass, since a fill
// count and a high-water mark substitute the seed values for unwritten entries.
module lzss_ring_decompressor #(
  parameter int unsigned MIN_MATCH_LEN = lzrd_pkg::MIN_MATCH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lzrd_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lzrd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        out_last_o
);

  import lzrd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PUT
  } state_e;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_ITEM = 2'd1,
    PH_HI   = 2'd2
  } phase_e;

  state_e              state_q;
  phase_e              phase_q;
  logic [BYTE_W-1:0]   flag_bits_q;
  logic [3:0]          flags_left_q;
  logic [BYTE_W-1:0]   pending_low_q;
  logic [PTR_W-1:0]    wr_pos_q;
  logic [PTR_W-1:0]    rd_pos_q;
  logic [FILL_W-1:0]   fill_q;
  logic [EVER_W-1:0]   ever_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                from_ram_q;
  logic                last_q;
  logic [BYTE_W-1:0]   lit_q;
  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                out_last_q;

  logic                in_acc;
  logic                slot_free;
  logic [PTR_W-1:0]    rel_pos;
  logic                written;
  logic                high_zone;
  logic                kept;
  logic [BYTE_W-1:0]   ram_rdata;
  logic [BYTE_W-1:0]   put_byte;
  logic [CNT_W-1:0]    raw_len;
  logic [CNT_W-1:0]    match_len;
  logic [PTR_W-1:0]    match_off;
  logic                ram_we;
  logic                ram_re;
  phase_e              next_phase;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  assign rel_pos   = rd_pos_q - PTR_W'(SEED_END);
  assign written   = fill_q > FILL_W'(rel_pos);
  assign high_zone = rd_pos_q >= PTR_W'(SEED_END);
  assign kept      = high_zone && (PTR_W'(ever_q) > rel_pos);

  always_comb begin
    if (!from_ram_q) begin
      put_byte = lit_q;
    end else if (written || kept) begin
      put_byte = ram_rdata;
    end else if (high_zone) begin
      put_byte = '0;
    end else begin
      put_byte = SPACE_BYTE;
    end
  end

  assign raw_len   = CNT_W'(in_byte_i[3:0]) + CNT_W'(MIN_MATCH_LEN + 1);
  assign match_len = (raw_len > CNT_W'(LOOKAHEAD)) ? CNT_W'(LOOKAHEAD) : raw_len;
  assign match_off = {in_byte_i[7:4], pending_low_q};
  assign next_phase = (flags_left_q == 4'd1) ? PH_FLAG : PH_ITEM;

  assign ram_we = (state_q == ST_PUT) && slot_free;
  assign ram_re = (state_q == ST_READ);

  lzrd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_SIZE)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_pos_q),
    .wdata_i(put_byte),
    .re_i   (ram_re),
    .raddr_i(rd_pos_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_FLAG;
      flag_bits_q   <= '0;
      flags_left_q  <= '0;
      pending_low_q <= '0;
      wr_pos_q      <= PTR_W'(SEED_END);
      rd_pos_q      <= '0;
      fill_q        <= '0;
      ever_q        <= '0;
      cnt_q         <= '0;
      from_ram_q    <= 1'b0;
      last_q        <= 1'b0;
      lit_q         <= '0;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q <= in_last_i;
            case (phase_q)
              PH_ITEM: begin
                if (flag_bits_q[0]) begin
                  lit_q        <= in_byte_i;
                  from_ram_q   <= 1'b0;
                  cnt_q        <= CNT_W'(1);
                  state_q      <= ST_PUT;
                  flag_bits_q  <= flag_bits_q >> 1;
                  flags_left_q <= flags_left_q - 4'd1;
                  phase_q      <= next_phase;
                end else begin
                  pending_low_q <= in_byte_i;
                  phase_q       <= PH_HI;
                end
              end
              PH_HI: begin
                rd_pos_q     <= match_off;
                from_ram_q   <= 1'b1;
                cnt_q        <= match_len;
                state_q      <= ST_READ;
                flag_bits_q  <= flag_bits_q >> 1;
                flags_left_q <= flags_left_q - 4'd1;
                phase_q      <= next_phase;
              end
              default: begin
                flag_bits_q  <= in_byte_i;
                flags_left_q <= FLAGS_PER_GROUP;
                phase_q      <= PH_ITEM;
              end
            endcase
            if (in_last_i && !(phase_q == PH_HI)
                && !((phase_q == PH_ITEM) && flag_bits_q[0])) begin
              wr_pos_q      <= PTR_W'(SEED_END);
              fill_q        <= '0;
              flag_bits_q   <= '0;
              flags_left_q  <= '0;
              pending_low_q <= '0;
              phase_q       <= PH_FLAG;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_PUT;
        end
        ST_PUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= put_byte;
            out_last_q  <= last_q && (cnt_q == CNT_W'(1));
            wr_pos_q    <= wr_pos_q + PTR_W'(1);
            rd_pos_q    <= rd_pos_q + PTR_W'(1);
            cnt_q       <= cnt_q - CNT_W'(1);
            if (fill_q != FILL_W'(RING_SIZE)) begin
              fill_q <= fill_q + FILL_W'(1);
            end
            if ((FILL_W'(ever_q) == fill_q) && (ever_q != EVER_W'(LOOKAHEAD))) begin
              ever_q <= ever_q + EVER_W'(1);
            end
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
              if (last_q) begin
                wr_pos_q      <= PTR_W'(SEED_END);
                fill_q        <= '0;
                flag_bits_q   <= '0;
                flags_left_q  <= '0;
                pending_low_q <= '0;
                phase_q       <= PH_FLAG;
              end
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hw/rtl/lzrd_checker.sv
// Port-level checker for the LZSS ring decompressor, with its bind statement.
`include "lzss_ring_decompressor_assert.svh"

module lzrd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [lzrd_pkg::BYTE_W-1:0] in_byte_i,
  input logic                        in_last_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lzrd_pkg::BYTE_W-1:0] out_byte_o,
  input logic                        out_last_o
);

  logic in_seen;

  assign in_seen = in_valid_i && (in_byte_i == in_byte_i) && (in_last_i == in_last_i);

  // A stalled output transaction keeps its valid and its payload.
  `LZRD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(out_last_o))

  // New output bytes are only produced while the block is busy with an input.
  `LZRD_ASSERT_IMP(a_load_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // The final byte of a stream returns the block to accepting input.
  `LZRD_ASSERT_IMP(a_last_idle, clk_i, rst_ni, $rose(out_valid_o) && out_last_o, !in_stall_o)

  // An input byte accepted while idle that leaves the block idle never produces output in the next cycle.
  `LZRD_ASSERT_IMP(a_idle_quiet, clk_i, rst_ni, $past(in_seen && !in_stall_o) && !$past(out_valid_o) && !in_stall_o, !$rose(out_valid_o))

endmodule

bind lzss_ring_decompressor lzrd_checker u_lzrd_checker (.*);
